// ----- rtl/rnp_pkg.sv -----
// Shared types and constants for the rectangle nearest-point block.
package rnp_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int FIELD_W        = 16;
  localparam int EXTENT_W       = 15;
  localparam int CFG_DATA_W     = 48;
  localparam int CFG_INDEX_W    = 3;
  localparam int DIST_W         = 17;
  localparam int RAD_W          = 2 * DIST_W;
  localparam int SQRT_PER_STAGE = 4;
  localparam int SQRT_STAGES    = (DIST_W + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;

  localparam logic [CFG_INDEX_W-1:0] REG_CENTER   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS_U   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS_V   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_U = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_V = 3'd4;

  localparam logic [CFG_DATA_W-1:0] CENTER_RESET = 48'h0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] AXIS_U_RESET = 48'h0000_0000_4000;
  localparam logic [CFG_DATA_W-1:0] AXIS_V_RESET = 48'h0000_4000_0000;
  localparam logic [EXTENT_W-1:0]   EXTENT_RESET = 15'd256;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] query_x;
    logic signed [COORD_WIDTH-1:0] query_y;
    logic signed [COORD_WIDTH-1:0] query_z;
  } query_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] near_x;
    logic signed [COORD_WIDTH-1:0] near_y;
    logic signed [COORD_WIDTH-1:0] near_z;
    logic        [DIST_W-1:0]      dist_res;
  } result_t;

endpackage

// ----- rtl/rect_nearest_point_top.sv -----
// Nearest point on a configured 3D oriented rectangle and the distance to it.
// An accepted query transaction runs through the arithmetic stages and then the root stages to out_valid;
// the square root retires four result bits per stage.
// Throughput: one transaction per cycle unless out_stall backs up a full pipe; bubbles collapse under it.
// Reset (synchronous, rst high): clears every stage valid bit and loads the register
// defaults (center at the origin, u = +x, v = +y, both half-extents 1.0).
module rect_nearest_point_top
  import rnp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  query_t                 in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output result_t                out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Derived widths
  localparam int W      = COORD_WIDTH;
  localparam int DW     = ((W > FIELD_W) ? W : FIELD_W) + 1;   // center - query
  localparam int PW     = DW + FIELD_W + 2;                    // raw projection sum
  localparam int PROJ_SHIFT = 6;                               // 2^-22 -> 2^-16
  localparam int BW     = PW - PROJ_SHIFT;                     // rounded projection
  localparam int SW     = EXTENT_W + 9;                        // clamped offset
  localparam int TW     = BW + 2;                              // s + 2*b
  localparam int TLO_W  = SW;                                  // low split of t
  localparam int TH_W   = TW - TLO_W;
  localparam int PLO_W  = SW + TLO_W + 1;
  localparam int PHI_W  = SW + TH_W;
  localparam int TMW    = SW + TW;                             // s*(s + 2b)
  localparam int DDW    = 2 * DW + 1;                          // d.d
  localparam int SQ_SHIFT = 16;
  localparam int SQW    = (((DDW + SQ_SHIFT) > TMW) ? (DDW + SQ_SHIFT) : TMW) + 2;
  localparam int NAW    = SW + FIELD_W + 2;                    // nearest point sum
  localparam int NEAR_SHIFT = 22;
  localparam int NRW    = NAW - NEAR_SHIFT;
  localparam int EW     = ((W > NRW) ? W : NRW) + 1;
  localparam int REM_W  = DIST_W + 2;
  localparam int NST    = 7 + SQRT_STAGES;
  localparam int LAST   = SQRT_STAGES - 1;

  localparam logic signed [PW-1:0]  PROJ_HALF = PW'(1 << (PROJ_SHIFT - 1));
  localparam logic signed [NAW-1:0] NEAR_HALF = NAW'(1 << (NEAR_SHIFT - 1));
  localparam logic signed [EW-1:0]  NEAR_MAX  = EW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [EW-1:0]  NEAR_MIN  = EW'(-(64'sd1 <<< (W - 1)));

  // Configuration registers; the user must write them only while the pipeline is drained (not enforced here)
  logic [CFG_DATA_W-1:0] center_packed;
  logic [CFG_DATA_W-1:0] axis_u_packed;
  logic [CFG_DATA_W-1:0] axis_v_packed;
  logic [EXTENT_W-1:0]   extent_u;
  logic [EXTENT_W-1:0]   extent_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_packed <= CENTER_RESET;
      axis_u_packed <= AXIS_U_RESET;
      axis_v_packed <= AXIS_V_RESET;
      extent_u      <= EXTENT_RESET;
      extent_v      <= EXTENT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER:   center_packed <= cfg_data;
        REG_AXIS_U:   axis_u_packed <= cfg_data;
        REG_AXIS_V:   axis_v_packed <= cfg_data;
        REG_EXTENT_U: extent_u      <= cfg_data[EXTENT_W-1:0];
        REG_EXTENT_V: extent_v      <= cfg_data[EXTENT_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Unpack the vector registers into components
  logic signed [FIELD_W-1:0] cen [3];
  logic signed [FIELD_W-1:0] ax_u [3];
  logic signed [FIELD_W-1:0] ax_v [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cen[k]  = $signed(center_packed[FIELD_W*k +: FIELD_W]);
      ax_u[k] = $signed(axis_u_packed[FIELD_W*k +: FIELD_W]);
      ax_v[k] = $signed(axis_v_packed[FIELD_W*k +: FIELD_W]);
    end
  end

  // Stage handshake: a stage loads when it is empty or its successor loads,
  // so bubbles collapse and a stalled output holds only what sits behind it.
  logic [NST-1:0] valid;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !valid[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  // Stage 0: difference d = center - query
  logic signed [DW-1:0] d_q [3];
  logic signed [DW-1:0] qx [3];

  always_comb begin
    qx[0] = DW'(in_data.query_x);
    qx[1] = DW'(in_data.query_y);
    qx[2] = DW'(in_data.query_z);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        d_q[k] <= DW'(cen[k]) - qx[k];
      end
    end
  end

  // Stage 1: per-component products for both projections and d.d
  logic signed [DW+FIELD_W-1:0] pu_q [3];
  logic signed [DW+FIELD_W-1:0] pv_q [3];
  logic signed [2*DW-1:0]       pd_q [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        pu_q[k] <= d_q[k] * ax_u[k];
        pv_q[k] <= d_q[k] * ax_v[k];
        pd_q[k] <= d_q[k] * d_q[k];
      end
    end
  end

  // Stage 2: sum the products, round projections to 2^-16
  logic signed [BW-1:0]  bu_q, bv_q;
  logic signed [DDW-1:0] dd2_q;
  logic signed [PW-1:0]  bu_sum, bv_sum;
  logic signed [DDW-1:0] dd_sum;

  always_comb begin
    bu_sum = PW'(pu_q[0]) + PW'(pu_q[1]) + PW'(pu_q[2]) + PROJ_HALF;
    bv_sum = PW'(pv_q[0]) + PW'(pv_q[1]) + PW'(pv_q[2]) + PROJ_HALF;
    dd_sum = DDW'(pd_q[0]) + DDW'(pd_q[1]) + DDW'(pd_q[2]);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      bu_q  <= bu_sum[PW-1:PROJ_SHIFT];
      bv_q  <= bv_sum[PW-1:PROJ_SHIFT];
      dd2_q <= dd_sum;
    end
  end

  // Stage 3: clamp the in-plane offsets to the extents, form s + 2b
  logic signed [SW-1:0]  su_q, sv_q;
  logic signed [TW-1:0]  tu_q, tv_q;
  logic signed [DDW-1:0] dd3_q;
  logic signed [SW-1:0]  eu, ev, su_n, sv_n;
  logic signed [BW-1:0]  eu_w, ev_w, nbu, nbv;
  logic signed [TW-1:0]  su_t, sv_t, bu_t, bv_t;

  always_comb begin
    eu   = $signed({1'b0, extent_u, 8'd0});
    ev   = $signed({1'b0, extent_v, 8'd0});
    eu_w = BW'(eu);
    ev_w = BW'(ev);
    nbu  = -bu_q;
    nbv  = -bv_q;
    priority if (bu_q > eu_w) begin
      su_n = -eu;
    end else if (bu_q < -eu_w) begin
      su_n = eu;
    end else begin
      su_n = nbu[SW-1:0];
    end
    priority if (bv_q > ev_w) begin
      sv_n = -ev;
    end else if (bv_q < -ev_w) begin
      sv_n = ev;
    end else begin
      sv_n = nbv[SW-1:0];
    end
    su_t = TW'(su_n);
    sv_t = TW'(sv_n);
    bu_t = TW'(bu_q);
    bv_t = TW'(bv_q);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      su_q  <= su_n;
      sv_q  <= sv_n;
      tu_q  <= su_t + (bu_t <<< 1);
      tv_q  <= sv_t + (bv_t <<< 1);
      dd3_q <= dd2_q;
    end
  end

  // Stage 4: split s*t into two partial products; nearest-point products
  logic signed [PLO_W-1:0]        plo_u_q, plo_v_q;
  logic signed [PHI_W-1:0]        phi_u_q, phi_v_q;
  logic signed [SW+FIELD_W-1:0]   nu_q [3];
  logic signed [SW+FIELD_W-1:0]   nv_q [3];
  logic signed [DDW-1:0]          dd4_q;
  logic signed [TLO_W:0]          tlo_u, tlo_v;
  logic signed [TH_W-1:0]         thi_u, thi_v;

  always_comb begin
    tlo_u = $signed({1'b0, tu_q[TLO_W-1:0]});
    tlo_v = $signed({1'b0, tv_q[TLO_W-1:0]});
    thi_u = $signed(tu_q[TW-1:TLO_W]);
    thi_v = $signed(tv_q[TW-1:TLO_W]);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      plo_u_q <= su_q * tlo_u;
      plo_v_q <= sv_q * tlo_v;
      phi_u_q <= su_q * thi_u;
      phi_v_q <= sv_q * thi_v;
      for (int k = 0; k < 3; k++) begin
        nu_q[k] <= su_q * ax_u[k];
        nv_q[k] <= sv_q * ax_v[k];
      end
      dd4_q <= dd3_q;
    end
  end

  // Stage 5: recombine partials, sum and round the nearest point, saturate
  logic signed [TMW-1:0]  term_u_q, term_v_q;
  logic signed [DDW-1:0]  dd5_q;
  logic signed [W-1:0]    near5_q [3];
  logic signed [TMW-1:0]  phu_w, phv_w, plu_w, plv_w;
  logic signed [NAW-1:0]  cw, nuw, nvw, acc;
  logic signed [EW-1:0]   rnd_e;
  logic signed [W-1:0]    near5_n [3];

  always_comb begin
    phu_w = TMW'(phi_u_q);
    phv_w = TMW'(phi_v_q);
    plu_w = TMW'(plo_u_q);
    plv_w = TMW'(plo_v_q);
    cw    = '0;
    nuw   = '0;
    nvw   = '0;
    acc   = '0;
    rnd_e = '0;
    for (int k = 0; k < 3; k++) begin
      cw    = NAW'(cen[k]);
      nuw   = NAW'(nu_q[k]);
      nvw   = NAW'(nv_q[k]);
      acc   = (cw <<< NEAR_SHIFT) + nuw + nvw + NEAR_HALF;
      rnd_e = EW'($signed(acc[NAW-1:NEAR_SHIFT]));
      priority if (rnd_e > NEAR_MAX) begin
        near5_n[k] = NEAR_MAX[W-1:0];
      end else if (rnd_e < NEAR_MIN) begin
        near5_n[k] = NEAR_MIN[W-1:0];
      end else begin
        near5_n[k] = rnd_e[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      term_u_q <= (phu_w <<< TLO_W) + plu_w;
      term_v_q <= (phv_w <<< TLO_W) + plv_w;
      dd5_q    <= dd4_q;
      near5_q  <= near5_n;
    end
  end

  // Stage 6: squared distance at 2^-32, clamp to the root's input range
  logic [RAD_W-1:0]      x6_q;
  logic signed [W-1:0]   near6_q [3];
  logic signed [SQW-1:0] ddw, tuw, tvw, sq;
  logic [RAD_W-1:0]      x6_n;

  always_comb begin
    ddw = SQW'(dd5_q);
    tuw = SQW'(term_u_q);
    tvw = SQW'(term_v_q);
    sq  = (ddw <<< SQ_SHIFT) + tuw + tvw;
    priority if (sq[SQW-1]) begin
      x6_n = '0;                 // skewed axes can drive it negative
    end else if (|sq[SQW-2:SQ_SHIFT+RAD_W]) begin
      x6_n = '1;                 // root saturates at full scale anyway
    end else begin
      x6_n = sq[SQ_SHIFT+RAD_W-1:SQ_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      x6_q    <= x6_n;
      near6_q <= near5_q;
    end
  end

  // Stages 7..: digit-recurrence square root, SQRT_PER_STAGE bits per stage
  logic [RAD_W-1:0]    sr_rad  [SQRT_STAGES];
  logic [REM_W-1:0]    sr_rem  [SQRT_STAGES];
  logic [DIST_W-1:0]   sr_root [SQRT_STAGES];
  logic signed [W-1:0] sr_near [SQRT_STAGES][3];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
    logic [RAD_W-1:0]    rad_in, rad_n;
    logic [REM_W-1:0]    rem_in, rem_n;
    logic [DIST_W-1:0]   root_in, root_n;
    logic signed [W-1:0] near_in [3];
    logic [REM_W+1:0]    tmp, diff;
    logic [REM_W-1:0]    trial;

    if (s == 0) begin : g_first
      assign rad_in  = x6_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign near_in = near6_q;
    end else begin : g_next
      assign rad_in  = sr_rad[s-1];
      assign rem_in  = sr_rem[s-1];
      assign root_in = sr_root[s-1];
      assign near_in = sr_near[s-1];
    end

    always_comb begin
      rad_n  = rad_in;
      rem_n  = rem_in;
      root_n = root_in;
      tmp    = '0;
      diff   = '0;
      trial  = '0;
      for (int j = 0; j < SQRT_PER_STAGE; j++) begin
        if (s * SQRT_PER_STAGE + j < DIST_W) begin
          tmp   = {rem_n, rad_n[RAD_W-1 -: 2]};
          rad_n = {rad_n[RAD_W-3:0], 2'b00};
          trial = {root_n, 2'b01};
          diff  = tmp - {2'b00, trial};
          if (tmp >= {2'b00, trial}) begin
            rem_n  = diff[REM_W-1:0];
            root_n = {root_n[DIST_W-2:0], 1'b1};
          end else begin
            rem_n  = tmp[REM_W-1:0];
            root_n = {root_n[DIST_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[7+s]) begin
        sr_rad[s]  <= rad_n;
        sr_rem[s]  <= rem_n;
        sr_root[s] <= root_n;
        sr_near[s] <= near_in;
      end
    end
  end

  // The last root stage is the output register
  assign out_valid         = valid[NST-1];
  assign out_data.near_x   = sr_near[LAST][0];
  assign out_data.near_y   = sr_near[LAST][1];
  assign out_data.near_z   = sr_near[LAST][2];
  assign out_data.dist_res = sr_root[LAST];

  // Input backpressure only arises from a full pipe behind a stalled output.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the pipeline has room");

  // A held clamp stage keeps its item and its offset.
  a_hold_mid: assert property (@(posedge clk) disable iff (rst)
    (valid[3] && !en[3]) |=> (valid[3] && $stable(su_q)))
    else $error("clamp stage changed while held");

  // Completed root leaves a remainder no larger than twice the root.
  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    valid[NST-1] |-> ({1'b0, sr_rem[LAST]} <= {2'b00, sr_root[LAST], 1'b0}))
    else $error("square root remainder out of range");

endmodule
